### src/bpfa_pkg.sv
`timescale 1ns / 1ps

package bpfa_pkg;

    // default geometry of the page map
    localparam int DEF_MAX_PAGE_COUNT  = 65536;
    localparam int DEF_PAGE_SHIFT      = 12;
    localparam int DEF_FIRST_FREE_PAGE = 512;

    // fixed field widths
    localparam int REQ_W     = 2;
    localparam int REL_W     = 32;
    localparam int ADDR_W    = 28;
    localparam int STATUS_W  = 2;
    localparam int COUNT_W   = 17;
    localparam int KB_W      = 22;
    localparam int KB_SHIFT  = 10;
    localparam int BYTES_W   = KB_W + KB_SHIFT + 1;
    localparam logic [BYTES_W-1:0] LOW_MEMORY_BYTES = BYTES_W'(1024 * 1024);

    // map words
    localparam int WORD_BITS  = 32;
    localparam int WORD_SHIFT = 5;

    // configuration port
    localparam int PDATA_W = 32;
    localparam int PADDR_W = 3;
    localparam logic REG_UPPER_KB = 1'b0;

    // request codes
    localparam logic [REQ_W-1:0] REQ_INIT  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_ALLOC = 2'd1;
    localparam logic [REQ_W-1:0] REQ_FREE  = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_MEMORY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_IGNORED   = 2'd2;

    // lowest clear bit of a map word (word must hold a zero)
    function automatic logic [WORD_SHIFT-1:0] first_zero(input logic [WORD_BITS-1:0] w);
        logic [WORD_SHIFT-1:0] idx;
        idx = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (!w[i]) idx = WORD_SHIFT'(i);
        end
        return idx;
    endfunction

endpackage

### src/bpfa_cfg.sv
`timescale 1ns / 1ps

module bpfa_cfg
    import bpfa_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output logic [KB_W-1:0]    o_upper_memory_kb
);

    logic [KB_W-1:0] r_upper_kb;
    logic            wr_go;

    assign pready = 1'b1;
    assign wr_go  = psel && penable && pwrite;

    // register write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upper_kb <= '0;
        end else if (wr_go && paddr[2] == REG_UPPER_KB) begin
            r_upper_kb <= pwdata[KB_W-1:0];
        end
    end

    // register readback
    always_comb begin
        unique case (paddr[2])
            REG_UPPER_KB: prdata = PDATA_W'(r_upper_kb);
            default:      prdata = '0;
        endcase
    end

    assign o_upper_memory_kb = r_upper_kb;

endmodule

### src/bpfa_core.sv
`timescale 1ns / 1ps

module bpfa_core
    import bpfa_pkg::*;
#(
    parameter int MAX_PAGE_COUNT  = DEF_MAX_PAGE_COUNT,
    parameter int PAGE_SHIFT      = DEF_PAGE_SHIFT,
    parameter int FIRST_FREE_PAGE = DEF_FIRST_FREE_PAGE
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    output logic                o_busy,
    input  logic [REQ_W-1:0]    i_req_type,
    input  logic [REL_W-1:0]    i_release_address,
    input  logic [KB_W-1:0]     i_upper_memory_kb,
    output logic                o_done,
    output logic [ADDR_W-1:0]   o_page_address,
    output logic [STATUS_W-1:0] o_status,
    output logic [COUNT_W-1:0]  o_free_pages,
    output logic [COUNT_W-1:0]  o_managed_pages
);

    localparam int MAP_WORDS = (MAX_PAGE_COUNT + WORD_BITS - 1) / WORD_BITS;
    localparam int WAW       = $clog2(MAP_WORDS);
    localparam int SW        = $clog2(MAP_WORDS + 1);
    localparam int CW        = $clog2(MAX_PAGE_COUNT + 1);
    localparam int BW        = $clog2(MAX_PAGE_COUNT + FIRST_FREE_PAGE + 64) + 1;
    localparam int PNW       = WAW + WORD_SHIFT;
    localparam int PAW       = PNW + PAGE_SHIFT;
    localparam logic [BW-1:0] FF_B  = BW'(FIRST_FREE_PAGE);
    localparam logic [BW-1:0] WB_B  = BW'(WORD_BITS);
    localparam logic [BW-1:0] WM1_B = BW'(WORD_BITS - 1);

    typedef enum logic [6:0] {
        S_IDLE       = 7'b0000001,
        S_INIT_SIZE  = 7'b0000010,
        S_INIT_COUNT = 7'b0000100,
        S_INIT_FILL  = 7'b0001000,
        S_ALLOC_SCAN = 7'b0010000,
        S_FREE_RD    = 7'b0100000,
        S_FREE_CHK   = 7'b1000000
    } t_state;

    // state and counters
    t_state               r_state, n_state;
    logic [REL_W-1:0]     r_addr, n_addr;
    logic [CW-1:0]        r_managed, n_managed;
    logic [CW-1:0]        r_free, n_free;
    logic [SW-1:0]        r_limit, n_limit;
    logic [SW-1:0]        r_scan, n_scan;
    logic                 r_pend, n_pend;
    logic [WAW-1:0]       r_pend_addr, n_pend_addr;
    logic                 r_done, n_done;
    logic [ADDR_W-1:0]    r_page_addr, n_page_addr;
    logic [STATUS_W-1:0]  r_status, n_status;
    logic [COUNT_W-1:0]   r_out_free, n_out_free;
    logic [COUNT_W-1:0]   r_out_total, n_out_total;

    // page map memory
    logic [WORD_BITS-1:0] r_map [MAP_WORDS];
    logic [WORD_BITS-1:0] r_rd_data;
    logic                 rd_en, wr_en;
    logic [WAW-1:0]       rd_addr, wr_addr;
    logic [WORD_BITS-1:0] wr_data;

    always_ff @(posedge i_clk) begin
        if (wr_en) r_map[wr_addr] <= wr_data;
        if (rd_en) r_rd_data <= r_map[rd_addr];
    end

    // page count sizing
    logic [BYTES_W-1:0] sized_bytes;
    logic [BYTES_W-1:0] mem_pages;
    logic [CW-1:0]      sized_pages;

    assign sized_bytes = {1'b0, i_upper_memory_kb, KB_SHIFT'(0)} + LOW_MEMORY_BYTES;
    assign mem_pages   = sized_bytes >> PAGE_SHIFT;
    assign sized_pages = (mem_pages > BYTES_W'(MAX_PAGE_COUNT)) ? CW'(MAX_PAGE_COUNT)
                                                                : mem_pages[CW-1:0];

    // free count and sweep length after init
    logic [BW-1:0] managed_b;
    logic [CW-1:0] init_free;
    logic [SW-1:0] init_limit;

    assign managed_b  = BW'(r_managed);
    assign init_free  = (managed_b > FF_B) ? CW'(managed_b - FF_B) : '0;
    assign init_limit = SW'((managed_b + WM1_B) >> WORD_SHIFT);

    // init fill word: zero for pages in [first free, managed)
    logic [BW-1:0]        base_b, lo_d, hi_d;
    logic [WORD_BITS-1:0] lo_mask, hi_mask, fill_word;

    always_comb begin
        base_b = BW'(r_scan) << WORD_SHIFT;
        lo_d   = FF_B - base_b;
        hi_d   = managed_b - base_b;
        if (base_b >= FF_B) begin
            lo_mask = '1;
        end else if (lo_d >= WB_B) begin
            lo_mask = '0;
        end else begin
            lo_mask = '1 << lo_d[WORD_SHIFT-1:0];
        end
        if (managed_b <= base_b) begin
            hi_mask = '0;
        end else if (hi_d >= WB_B) begin
            hi_mask = '1;
        end else begin
            hi_mask = ~('1 << hi_d[WORD_SHIFT-1:0]);
        end
        fill_word = ~(lo_mask & hi_mask);
    end

    // scan word check
    logic                  word_has_free;
    logic [WORD_SHIFT-1:0] zero_bit;
    logic [PNW-1:0]        found_page;
    logic [PAW-1:0]        found_addr;

    assign word_has_free = (r_rd_data != '1);
    assign zero_bit      = first_zero(r_rd_data);
    assign found_page    = {r_pend_addr, zero_bit};
    assign found_addr    = PAW'(found_page) << PAGE_SHIFT;

    // release address decode
    logic [REL_W-1:0]      rel_idx;
    logic                  rel_in_range;
    logic [WAW-1:0]        rel_word;
    logic [WORD_SHIFT-1:0] rel_bit;

    assign rel_idx      = r_addr >> PAGE_SHIFT;
    assign rel_in_range = rel_idx < REL_W'(r_managed);
    assign rel_word     = rel_idx[WORD_SHIFT +: WAW];
    assign rel_bit      = rel_idx[WORD_SHIFT-1:0];

    logic found_now, issue;

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_addr      = r_addr;
        n_managed   = r_managed;
        n_free      = r_free;
        n_limit     = r_limit;
        n_scan      = r_scan;
        n_pend      = r_pend;
        n_pend_addr = r_pend_addr;
        n_done      = 1'b0;
        n_page_addr = r_page_addr;
        n_status    = r_status;
        n_out_free  = r_out_free;
        n_out_total = r_out_total;
        rd_en       = 1'b0;
        rd_addr     = r_scan[WAW-1:0];
        wr_en       = 1'b0;
        wr_addr     = r_scan[WAW-1:0];
        wr_data     = fill_word;
        found_now   = r_pend && word_has_free;
        issue       = !found_now && (r_scan < r_limit);

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_addr = i_release_address;
                    n_scan = '0;
                    n_pend = 1'b0;
                    unique case (i_req_type)
                        REQ_INIT:  n_state = S_INIT_SIZE;
                        REQ_ALLOC: n_state = S_ALLOC_SCAN;
                        REQ_FREE:  n_state = S_FREE_RD;
                        default: begin
                            n_done      = 1'b1;
                            n_page_addr = '0;
                            n_status    = ST_OK;
                        end
                    endcase
                end
            end
            S_INIT_SIZE: begin
                n_managed = sized_pages;
                n_state   = S_INIT_COUNT;
            end
            S_INIT_COUNT: begin
                n_free  = init_free;
                n_limit = init_limit;
                n_scan  = '0;
                n_state = S_INIT_FILL;
            end
            S_INIT_FILL: begin
                if (r_scan < r_limit) begin
                    wr_en  = 1'b1;
                    n_scan = r_scan + SW'(1);
                end else begin
                    n_done      = 1'b1;
                    n_page_addr = '0;
                    n_status    = ST_OK;
                    n_state     = S_IDLE;
                end
            end
            S_ALLOC_SCAN: begin
                // reads run one word ahead of the check
                n_pend      = issue;
                n_pend_addr = r_scan[WAW-1:0];
                if (issue) begin
                    rd_en  = 1'b1;
                    n_scan = r_scan + SW'(1);
                end
                if (found_now) begin
                    wr_en       = 1'b1;
                    wr_addr     = r_pend_addr;
                    wr_data     = r_rd_data | (WORD_BITS'(1) << zero_bit);
                    n_free      = (r_free != '0) ? r_free - CW'(1) : r_free;
                    n_done      = 1'b1;
                    n_page_addr = ADDR_W'(found_addr);
                    n_status    = ST_OK;
                    n_state     = S_IDLE;
                end else if (!issue) begin
                    n_done      = 1'b1;
                    n_page_addr = '0;
                    n_status    = ST_NO_MEMORY;
                    n_state     = S_IDLE;
                end
            end
            S_FREE_RD: begin
                if (rel_in_range) begin
                    rd_en   = 1'b1;
                    rd_addr = rel_word;
                    n_state = S_FREE_CHK;
                end else begin
                    n_done      = 1'b1;
                    n_page_addr = '0;
                    n_status    = ST_IGNORED;
                    n_state     = S_IDLE;
                end
            end
            S_FREE_CHK: begin
                n_done      = 1'b1;
                n_page_addr = '0;
                n_state     = S_IDLE;
                if (r_rd_data[rel_bit]) begin
                    wr_en    = 1'b1;
                    wr_addr  = rel_word;
                    wr_data  = r_rd_data & ~(WORD_BITS'(1) << rel_bit);
                    n_free   = r_free + CW'(1);
                    n_status = ST_OK;
                end else begin
                    n_status = ST_IGNORED;
                end
            end
            default: n_state = S_IDLE;
        endcase

        // counts reported with every result
        if (n_done) begin
            n_out_free  = COUNT_W'(n_free);
            n_out_total = COUNT_W'(n_managed);
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_managed <= '0;
            r_free    <= '0;
            r_limit   <= '0;
            r_scan    <= '0;
            r_pend    <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_managed <= n_managed;
            r_free    <= n_free;
            r_limit   <= n_limit;
            r_scan    <= n_scan;
            r_pend    <= n_pend;
            r_done    <= n_done;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_addr      <= n_addr;
        r_pend_addr <= n_pend_addr;
        r_page_addr <= n_page_addr;
        r_status    <= n_status;
        r_out_free  <= n_out_free;
        r_out_total <= n_out_total;
    end

    assign o_busy          = (r_state != S_IDLE);
    assign o_done          = r_done;
    assign o_page_address  = r_page_addr;
    assign o_status        = r_status;
    assign o_free_pages    = r_out_free;
    assign o_managed_pages = r_out_total;

endmodule

### src/bitmap_page_frame_allocator.sv
`timescale 1ns / 1ps
// First-fit page frame allocator, one used bit per page, bitmap kept in
// a single-port-write, single-port-read memory of 32-bit words.
// Requests: start is sampled with i_req_type / i_release_address and taken
// when busy is low. busy stays high until the request is finished.
// Results: o_done pulses for one cycle with o_page_address, o_status,
// o_free_pages and o_managed_pages; the receiver always takes them.
// Steps from start to o_done:
//   init:  size, count, then fill the map (one map word written a cycle)
//   alloc: read map words in order until one holds a clear bit or none is left
//   free:  read, check and write back; no read when out of range
//   unused code: o_done with status OK, busy stays low
// A new request may be taken in the cycle o_done is shown.
// Configuration (upper_memory_kb at byte address 0) goes over the APB port
// and is read only by init; write it only while busy is low.
// Reset clears the counts to zero, so alloc returns no memory and free is
// ignored until the first init; the map memory is not cleared by reset.
module bitmap_page_frame_allocator
    import bpfa_pkg::*;
#(
    parameter int MAX_PAGE_COUNT  = DEF_MAX_PAGE_COUNT,
    parameter int PAGE_SHIFT      = DEF_PAGE_SHIFT,
    parameter int FIRST_FREE_PAGE = DEF_FIRST_FREE_PAGE
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [REQ_W-1:0]    i_req_type,
    input  logic [REL_W-1:0]    i_release_address,
    output logic                o_done,
    output logic [ADDR_W-1:0]   o_page_address,
    output logic [STATUS_W-1:0] o_status,
    output logic [COUNT_W-1:0]  o_free_pages,
    output logic [COUNT_W-1:0]  o_managed_pages,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0]  pwdata,
    output logic [PDATA_W-1:0]  prdata,
    output logic                pready
);

    logic [KB_W-1:0] upper_kb;

    // configuration register
    bpfa_cfg u_cfg (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .o_upper_memory_kb (upper_kb)
    );

    // sequencer and page map
    bpfa_core #(
        .MAX_PAGE_COUNT  (MAX_PAGE_COUNT),
        .PAGE_SHIFT      (PAGE_SHIFT),
        .FIRST_FREE_PAGE (FIRST_FREE_PAGE)
    ) u_core (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_start           (start),
        .o_busy            (busy),
        .i_req_type        (i_req_type),
        .i_release_address (i_release_address),
        .i_upper_memory_kb (upper_kb),
        .o_done            (o_done),
        .o_page_address    (o_page_address),
        .o_status          (o_status),
        .o_free_pages      (o_free_pages),
        .o_managed_pages   (o_managed_pages)
    );

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import bpfa_pkg::*;

    localparam int CLK_HALF    = 5;
    localparam int PAGE_COUNT  = DEF_MAX_PAGE_COUNT;
    localparam int PG_SHIFT    = DEF_PAGE_SHIFT;
    localparam int LOW_FREE_PG = DEF_FIRST_FREE_PAGE;
    localparam int N_RANDOM    = 1400;
    localparam int MAX_REPORTS = 10;

    // request code with no operation behind it
    localparam logic [REQ_W-1:0]   REQ_UNUSED = 2'd3;
    localparam logic [KB_W-1:0]    KB_MAX     = '1;
    localparam logic [PADDR_W-1:0] KB_ADDR    = PADDR_W'(4 * REG_UPPER_KB);

    typedef struct packed {
        logic [ADDR_W-1:0]   page_addr;
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  free_cnt;
        logic [COUNT_W-1:0]  total_cnt;
    } t_alloc_outcome;

    // page map mirror and the outcomes still owed by the block
    class alloc_scoreboard;
        bit              used_map [PAGE_COUNT];
        int unsigned     free_cnt;
        int unsigned     total_cnt;
        logic [KB_W-1:0] upper_kb;
        t_alloc_outcome  pending_outcomes [$];
        int              mismatches;

        function new();
            used_map   = '{default: 1'b1};
            free_cnt   = 0;
            total_cnt  = 0;
            upper_kb   = '0;
            mismatches = 0;
        endfunction

        function void flag(string msg);
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
                $display("%0t: %s", $time, msg);
            end
        endfunction

        // update the mirror for one accepted request, queue its outcome
        function t_alloc_outcome predict_outcome(logic [REQ_W-1:0] req,
                                                 logic [REL_W-1:0] addr);
            t_alloc_outcome  o;
            longint unsigned bytes;
            longint unsigned pages;
            int unsigned     page;
            int unsigned     idx;
            bit              found;
            o = '0;
            case (req)
                REQ_INIT: begin
                    bytes = upper_kb;
                    bytes = bytes * 1024 + 1024 * 1024;
                    pages = bytes >> PG_SHIFT;
                    if (pages > PAGE_COUNT) pages = PAGE_COUNT;
                    total_cnt = 32'(pages);
                    used_map  = '{default: 1'b1};
                    free_cnt  = 0;
                    for (int p = LOW_FREE_PG; p < total_cnt; p++) begin
                        used_map[p] = 1'b0;
                        free_cnt++;
                    end
                end
                REQ_ALLOC: begin
                    found = 1'b0;
                    page  = 0;
                    for (int p = 0; p < total_cnt; p++) begin
                        if (!used_map[p]) begin
                            page  = p;
                            found = 1'b1;
                            break;
                        end
                    end
                    if (found) begin
                        used_map[page] = 1'b1;
                        if (free_cnt > 0) free_cnt--;
                        o.page_addr = ADDR_W'(page << PG_SHIFT);
                    end else begin
                        o.status = ST_NO_MEMORY;
                    end
                end
                REQ_FREE: begin
                    idx = addr >> PG_SHIFT;
                    if (idx < total_cnt && used_map[idx]) begin
                        used_map[idx] = 1'b0;
                        free_cnt++;
                    end else begin
                        o.status = ST_IGNORED;
                    end
                end
                default: begin
                end
            endcase
            o.free_cnt  = COUNT_W'(free_cnt);
            o.total_cnt = COUNT_W'(total_cnt);
            pending_outcomes.push_back(o);
            return o;
        endfunction

        // compare one result with the oldest owed outcome
        function void check_result(t_alloc_outcome got);
            t_alloc_outcome want;
            if (pending_outcomes.size() == 0) begin
                flag($sformatf("result with nothing owed: addr %h status %0d free %0d total %0d",
                               got.page_addr, got.status, got.free_cnt, got.total_cnt));
                return;
            end
            want = pending_outcomes.pop_front();
            if (got.page_addr !== want.page_addr)
                flag($sformatf("page_address: expected %h, got %h",
                               want.page_addr, got.page_addr));
            if (got.status !== want.status)
                flag($sformatf("status: expected %0d, got %0d", want.status, got.status));
            if (got.free_cnt !== want.free_cnt)
                flag($sformatf("free_pages: expected %0d, got %0d",
                               want.free_cnt, got.free_cnt));
            if (got.total_cnt !== want.total_cnt)
                flag($sformatf("managed page count: expected %0d, got %0d",
                               want.total_cnt, got.total_cnt));
        endfunction
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    logic [REQ_W-1:0]    i_req_type;
    logic [REL_W-1:0]    i_release_address;
    logic                o_done;
    logic [ADDR_W-1:0]   o_page_address;
    logic [STATUS_W-1:0] o_status;
    logic [COUNT_W-1:0]  o_free_pages;
    logic [COUNT_W-1:0]  o_managed_pages;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    alloc_scoreboard sb;
    t_alloc_outcome  seen;
    int unsigned     granted_pages [$];
    int unsigned     released_pages [$];
    bit              quiet;

    bitmap_page_frame_allocator u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_req_type        (i_req_type),
        .i_release_address (i_release_address),
        .o_done            (o_done),
        .o_page_address    (o_page_address),
        .o_status          (o_status),
        .o_free_pages      (o_free_pages),
        .o_managed_pages   (o_managed_pages),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    // clock
    initial i_clk = 1'b0;
    always #(CLK_HALF) i_clk = ~i_clk;

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_done === 1'b1) begin
            seen = '{page_addr: o_page_address, status: o_status,
                     free_cnt: o_free_pages, total_cnt: o_managed_pages};
            sb.check_result(seen);
        end
    end

    // idle cycles before a request: mostly none or short, a few long
    function automatic int pick_gap();
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 4);
        return $urandom_range(10, 60);
    endfunction

    // issue one request and record it once accepted
    task automatic send_request(input logic [REQ_W-1:0] req, input logic [REL_W-1:0] addr);
        int             gap;
        t_alloc_outcome o;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            start = 1'b0;
            repeat (gap) begin
                // junk on the request fields while start is low
                i_req_type        = REQ_W'($urandom);
                i_release_address = $urandom;
                @(negedge i_clk);
            end
        end
        start             = 1'b1;
        i_req_type        = req;
        i_release_address = addr;
        do @(posedge i_clk); while (busy !== 1'b0);
        o = sb.predict_outcome(req, addr);
        // keep track of pages handed out and given back
        if (req == REQ_INIT) begin
            granted_pages.delete();
            released_pages.delete();
        end else if (req == REQ_ALLOC && o.status == ST_OK) begin
            granted_pages.push_back(o.page_addr >> PG_SHIFT);
        end else if (req == REQ_FREE && o.status == ST_OK) begin
            released_pages.push_back(addr >> PG_SHIFT);
            if (released_pages.size() > 16) void'(released_pages.pop_front());
        end
    endtask

    // let every owed result come back and the block settle
    task automatic wait_idle();
        @(negedge i_clk);
        start = 1'b0;
        while (sb.pending_outcomes.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
    endtask

    // write upper_memory_kb, then read it back
    task automatic write_upper_kb(input logic [KB_W-1:0] kb);
        logic [PDATA_W-1:0] rd;
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = KB_ADDR;
        pwdata  = PDATA_W'(kb);
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        sb.upper_kb = kb;
        @(negedge i_clk);
        penable = 1'b0;
        pwrite  = 1'b0;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        rd = prdata;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        if (rd !== PDATA_W'(kb))
            sb.flag($sformatf("upper_memory_kb readback: expected %h, got %h", kb, rd));
    endtask

    // one random request, biased toward alloc and free of granted pages
    task automatic random_request();
        int          r;
        int unsigned k;
        int unsigned pg;
        r = $urandom_range(0, 99);
        if (r < 50) begin
            send_request(REQ_ALLOC, $urandom);
        end else if (r < 78 && granted_pages.size() > 0) begin
            k  = $urandom_range(0, granted_pages.size() - 1);
            pg = granted_pages[k];
            granted_pages.delete(k);
            send_request(REQ_FREE, (pg << PG_SHIFT) | $urandom_range(0, (1 << PG_SHIFT) - 1));
        end else if (r < 84 && released_pages.size() > 0) begin
            // free again, may or may not have been handed out since
            k = $urandom_range(0, released_pages.size() - 1);
            send_request(REQ_FREE, (released_pages[k] << PG_SHIFT) | $urandom_range(0, 255));
        end else if (r < 90) begin
            // pages below the first free page
            send_request(REQ_FREE, $urandom_range(0, (LOW_FREE_PG << PG_SHIFT) - 1));
        end else if (r < 95) begin
            // around the top of the managed range
            send_request(REQ_FREE, $urandom_range(0, ((sb.total_cnt + 4) << PG_SHIFT) - 1));
        end else if (r < 98) begin
            send_request(REQ_FREE, $urandom);
        end else if (r < 99) begin
            send_request(REQ_UNUSED, $urandom);
        end else begin
            send_request(REQ_INIT, $urandom);
        end
    endtask

    // run limit
    initial begin
        #(200_000_000);
        $display("CHECK FAILED");
        $finish;
    end

    // stimulus
    initial begin
        int          issued;
        int          r;
        int          len;
        int unsigned nfree;
        logic [KB_W-1:0] kb;

        sb                = new();
        quiet             = 1'b0;
        i_rst_n           = 1'b0;
        start             = 1'b0;
        i_req_type        = REQ_INIT;
        i_release_address = '0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // before any init: no memory, free ignored, unused code
        send_request(REQ_ALLOC, 32'h0);
        send_request(REQ_FREE, 32'h0020_0000);
        send_request(REQ_UNUSED, 32'hFFFF_FFFF);

        // smallest setting: 256 pages, none free until a low page is released
        wait_idle();
        write_upper_kb('0);
        send_request(REQ_INIT, 32'h0);
        send_request(REQ_ALLOC, 32'h0);
        send_request(REQ_FREE, 32'h0000_0000);
        send_request(REQ_ALLOC, 32'h0);

        // one free page: the first free page itself
        wait_idle();
        write_upper_kb(KB_W'(1028));
        send_request(REQ_INIT, 32'h0);
        send_request(REQ_ALLOC, 32'h0);
        send_request(REQ_ALLOC, 32'h0);
        send_request(REQ_FREE, 32'h0020_0FFF);
        send_request(REQ_FREE, 32'h0020_0000);
        send_request(REQ_FREE, 32'hFFFF_FFFF);
        send_request(REQ_FREE, 32'h0020_1000);

        // largest setting, saturated page count
        wait_idle();
        write_upper_kb(KB_MAX);
        send_request(REQ_INIT, 32'h0);
        send_request(REQ_ALLOC, 32'h0);
        send_request(REQ_FREE, 32'h0FFF_F000);
        send_request(REQ_FREE, 32'h1000_0000);
        send_request(REQ_FREE, 32'h001F_F000);
        send_request(REQ_UNUSED, 32'h0);
        send_request(REQ_INIT, 32'hFFFF_FFFF);

        // random phases, each with its own setting and an init
        issued = 0;
        while (issued < N_RANDOM) begin
            wait_idle();
            r = $urandom_range(0, 99);
            if (r < 60) begin
                nfree = $urandom_range(0, 40);
                kb    = KB_W'((256 + nfree) * 4 + $urandom_range(0, 3));
                len   = 2 * nfree + $urandom_range(8, 20);
            end else if (r < 85) begin
                kb  = KB_W'($urandom_range(0, 8000));
                len = $urandom_range(30, 60);
            end else if (r < 93) begin
                kb  = KB_W'($urandom_range(0, KB_MAX));
                len = 25;
            end else begin
                kb  = KB_MAX;
                len = 25;
            end
            quiet = ($urandom_range(0, 4) == 0);
            write_upper_kb(kb);
            send_request(REQ_INIT, $urandom);
            issued++;
            repeat (len) begin
                random_request();
                issued++;
            end
        end

        // drain and settle
        wait_idle();
        repeat (16) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending_outcomes.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

### sim.f
src/bpfa_pkg.sv
src/bpfa_cfg.sv
src/bpfa_core.sv
src/bitmap_page_frame_allocator.sv
dv/tb_top.sv
